>>> rtl/jfd_pkg.sv
`default_nettype none

package jfd_pkg;

    localparam int SLOT_BYTES_DEF = 256;
    localparam int SLOTS_DEF      = 4;

    localparam int BYTE_W  = 8;
    localparam int SLOT_W  = 2;
    localparam int POS_W   = 8;
    localparam int PEND_W  = 3;
    localparam int DEPTH_W = 8;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t REG_OPEN  = 1'b0;
    localparam cfg_idx_t REG_CLOSE = 1'b1;

    localparam logic CMD_BYTE    = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    localparam logic [BYTE_W-1:0]  QUOTE_DOUBLE = 8'h22;
    localparam logic [BYTE_W-1:0]  QUOTE_SINGLE = 8'h27;
    localparam logic [BYTE_W-1:0]  BLANK_LIMIT  = 8'd32;
    localparam logic [DEPTH_W-1:0] DEPTH_MAX    = 8'd255;

    localparam logic [BYTE_W-1:0] OPEN_RESET  = 8'd123;
    localparam logic [BYTE_W-1:0] CLOSE_RESET = 8'd125;

    typedef struct packed {
        logic              write_valid;
        logic [SLOT_W-1:0] slot;
        logic [POS_W-1:0]  position;
        logic [BYTE_W-1:0] byte_out;
        logic              frame_done;
        logic              overflow;
        logic [PEND_W-1:0] pending_frames;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/jfd_in_if.sv
`default_nettype none

interface jfd_in_if;
    logic                          valid;
    logic                          ready;
    logic                          cmd;
    logic [jfd_pkg::BYTE_W-1:0]    data_byte;

    modport source (output valid, output cmd, output data_byte, input ready);
    modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

`default_nettype wire

>>> rtl/jfd_out_if.sv
`default_nettype none

interface jfd_out_if;
    logic                          valid;
    logic                          ready;
    logic                          write_valid;
    logic [jfd_pkg::SLOT_W-1:0]    slot;
    logic [jfd_pkg::POS_W-1:0]     position;
    logic [jfd_pkg::BYTE_W-1:0]    byte_out;
    logic                          frame_done;
    logic                          overflow;
    logic [jfd_pkg::PEND_W-1:0]    pending_frames;

    modport source (output valid, output write_valid, output slot, output position,
                    output byte_out, output frame_done, output overflow,
                    output pending_frames, input ready);
    modport sink   (input valid, input write_valid, input slot, input position,
                    input byte_out, input frame_done, input overflow,
                    input pending_frames, output ready);
endinterface

`default_nettype wire

>>> rtl/jfd_step.sv
`default_nettype none

module jfd_step #(
    parameter int SLOT_BYTES = jfd_pkg::SLOT_BYTES_DEF,
    parameter int SLOTS      = jfd_pkg::SLOTS_DEF,
    localparam int FILL_W    = $clog2(SLOT_BYTES + 1),
    localparam int CSLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1,
    localparam int CPEND_W   = $clog2(SLOTS + 1)
) (
    input  wire logic                          cmd,
    input  wire logic [jfd_pkg::BYTE_W-1:0]    data_byte,
    input  wire logic [jfd_pkg::BYTE_W-1:0]    open_byte,
    input  wire logic [jfd_pkg::BYTE_W-1:0]    close_byte,
    input  wire logic                          in_frame,
    input  wire logic [jfd_pkg::DEPTH_W-1:0]   nest_depth,
    input  wire logic                          in_string,
    input  wire logic [FILL_W-1:0]             fill_count,
    input  wire logic [CSLOT_W-1:0]            current_slot,
    input  wire logic [CPEND_W-1:0]            frames_pending,
    output logic                               in_frame_next,
    output logic [jfd_pkg::DEPTH_W-1:0]        nest_depth_next,
    output logic                               in_string_next,
    output logic [FILL_W-1:0]                  fill_count_next,
    output logic [CSLOT_W-1:0]                 current_slot_next,
    output logic [CPEND_W-1:0]                 frames_pending_next,
    output jfd_pkg::result_t                   result
);
    import jfd_pkg::*;

    logic              str_tog;
    logic              keep;
    logic [DEPTH_W-1:0] depth_up;
    logic [31:0]       slot_wide;
    logic [31:0]       fill_wide;

    assign slot_wide = 32'(current_slot);
    assign fill_wide = 32'(fill_count);

    always_comb
    begin
        in_frame_next       = in_frame;
        nest_depth_next     = nest_depth;
        in_string_next      = in_string;
        fill_count_next     = fill_count;
        current_slot_next   = current_slot;
        frames_pending_next = frames_pending;
        result              = '0;
        str_tog  = in_string ^ ((data_byte == QUOTE_DOUBLE) || (data_byte == QUOTE_SINGLE));
        keep     = str_tog || (data_byte > BLANK_LIMIT);
        depth_up = ((data_byte == open_byte) && (nest_depth < DEPTH_MAX))
                   ? nest_depth + DEPTH_W'(1) : nest_depth;

        if (cmd == CMD_RELEASE)
        begin
            if (frames_pending != '0)
                frames_pending_next = frames_pending - CPEND_W'(1);
        end
        else if (!in_frame)
        begin
            if (data_byte == open_byte)
            begin
                in_frame_next      = 1'b1;
                nest_depth_next    = DEPTH_W'(1);
                in_string_next     = 1'b0;
                fill_count_next    = FILL_W'(1);
                result.write_valid = 1'b1;
                result.slot        = slot_wide[SLOT_W-1:0];
                result.byte_out    = data_byte;
            end
        end
        else
        begin
            in_string_next = str_tog;
            if (keep)
            begin
                if (fill_count >= FILL_W'(SLOT_BYTES))
                begin
                    // slot full: drop the frame and forget pending frames
                    result.overflow     = 1'b1;
                    in_frame_next       = 1'b0;
                    nest_depth_next     = '0;
                    in_string_next      = 1'b0;
                    fill_count_next     = '0;
                    frames_pending_next = '0;
                end
                else
                begin
                    result.write_valid = 1'b1;
                    result.slot        = slot_wide[SLOT_W-1:0];
                    result.position    = fill_wide[POS_W-1:0];
                    result.byte_out    = data_byte;
                    fill_count_next    = fill_count + FILL_W'(1);
                    nest_depth_next    = depth_up;
                    if (data_byte == close_byte)
                    begin
                        if (depth_up != '0)
                            nest_depth_next = depth_up - DEPTH_W'(1);
                        if (depth_up <= DEPTH_W'(1))
                        begin
                            result.frame_done = 1'b1;
                            if (frames_pending < CPEND_W'(SLOTS))
                            begin
                                current_slot_next = (current_slot == CSLOT_W'(SLOTS - 1))
                                    ? '0 : current_slot + CSLOT_W'(1);
                                frames_pending_next = frames_pending + CPEND_W'(1);
                            end
                            in_frame_next   = 1'b0;
                            nest_depth_next = '0;
                            in_string_next  = 1'b0;
                            fill_count_next = '0;
                        end
                    end
                end
            end
        end
        result.pending_frames = PEND_W'(frames_pending_next);
    end

endmodule

`default_nettype wire

>>> rtl/json_frame_delimiter.sv
// JSON frame delimiter
//
// in_ch carries one request per received byte (cmd = byte) or per frame taken
// by the consumer (cmd = release). out_ch returns exactly one result per
// request: the byte to store with its slot and position when write_valid is
// set, plus frame_done, overflow and the pending frame count after the step.
// Both channels use a valid/ready handshake; a request moves on the edge
// where both are high.
// The result is registered and shows from the cycle after the request is
// accepted. Throughput is one request per cycle, set by the single result
// register; in_ch.ready stays high while that register is empty or drained
// in the same cycle, so a stalled receiver holds the result and back-pressures
// the sender only once that register is occupied.
// Reset (rst_n low) clears all parsing state, the slot pointer and the
// pending count, and loads open_byte = '{' and close_byte = '}'.
// The user must write the configuration port (cfg_we, cfg_index, cfg_data) only
// while no request is outstanding; the block itself does not enforce it.
`default_nettype none

module json_frame_delimiter #(
    parameter int SLOT_BYTES = jfd_pkg::SLOT_BYTES_DEF,
    parameter int SLOTS      = jfd_pkg::SLOTS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    jfd_in_if.sink                                in_ch,
    jfd_out_if.source                             out_ch,
    input  wire logic                             cfg_we,
    input  wire logic [jfd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [jfd_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import jfd_pkg::*;

    localparam int FILL_W  = $clog2(SLOT_BYTES + 1);
    localparam int CSLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CPEND_W = $clog2(SLOTS + 1);

    logic [BYTE_W-1:0]  open_reg;
    logic [BYTE_W-1:0]  close_reg;
    logic               in_frame_reg;
    logic [DEPTH_W-1:0] depth_reg;
    logic               in_string_reg;
    logic [FILL_W-1:0]  fill_reg;
    logic [CSLOT_W-1:0] slot_reg;
    logic [CPEND_W-1:0] pend_reg;

    logic               in_frame_next;
    logic [DEPTH_W-1:0] depth_next;
    logic               in_string_next;
    logic [FILL_W-1:0]  fill_next;
    logic [CSLOT_W-1:0] slot_next;
    logic [CPEND_W-1:0] pend_next;

    result_t            res_next;
    result_t            res_reg;
    logic               out_valid_reg;
    logic               accept;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;

    jfd_step #(
        .SLOT_BYTES (SLOT_BYTES),
        .SLOTS      (SLOTS)
    ) u_step (
        .cmd                 (in_ch.cmd),
        .data_byte           (in_ch.data_byte),
        .open_byte           (open_reg),
        .close_byte          (close_reg),
        .in_frame            (in_frame_reg),
        .nest_depth          (depth_reg),
        .in_string           (in_string_reg),
        .fill_count          (fill_reg),
        .current_slot        (slot_reg),
        .frames_pending      (pend_reg),
        .in_frame_next       (in_frame_next),
        .nest_depth_next     (depth_next),
        .in_string_next      (in_string_next),
        .fill_count_next     (fill_next),
        .current_slot_next   (slot_next),
        .frames_pending_next (pend_next),
        .result              (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg  <= OPEN_RESET;
            close_reg <= CLOSE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_OPEN:  open_reg  <= cfg_data;
                REG_CLOSE: close_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg  <= 1'b0;
            depth_reg     <= '0;
            in_string_reg <= 1'b0;
            fill_reg      <= '0;
            slot_reg      <= '0;
            pend_reg      <= '0;
        end
        else if (accept)
        begin
            in_frame_reg  <= in_frame_next;
            depth_reg     <= depth_next;
            in_string_reg <= in_string_next;
            fill_reg      <= fill_next;
            slot_reg      <= slot_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            res_reg <= res_next;
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.write_valid    = res_reg.write_valid;
    assign out_ch.slot           = res_reg.slot;
    assign out_ch.position       = res_reg.position;
    assign out_ch.byte_out       = res_reg.byte_out;
    assign out_ch.frame_done     = res_reg.frame_done;
    assign out_ch.overflow       = res_reg.overflow;
    assign out_ch.pending_frames = res_reg.pending_frames;

`ifndef NO_ASSERTIONS
    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= CPEND_W'(SLOTS))
        else $error("pending frame count above slot count");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(SLOT_BYTES))
        else $error("fill count beyond slot size");

    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !in_frame_reg |-> (depth_reg == '0 && fill_reg == '0 && !in_string_reg))
        else $error("parse state not clear while idle");

    a_ovf_nowrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(res_reg.overflow && res_reg.write_valid))
        else $error("overflow result carries a write");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ch.ready) |=> (out_valid_reg && $stable(res_reg)))
        else $error("result lost while receiver stalled");
`endif

endmodule

`default_nettype wire
